>>> src/fpm_pkg.sv
// Shared types, codes and constants for the fragment pool manager.
package fpm_pkg;

  localparam int IDX_W   = 6;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int ADDR_W  = 26;
  localparam int COUNT_W = 7;
  localparam int BYTES_W = 21;
  localparam int CFG_W   = 21;

  localparam logic [COUNT_W-1:0] FRAG_COUNT_RESET = 7'd64;
  localparam int                 FRAG_BYTES_RESET = 4096;

  typedef enum logic [ACT_W-1:0] {
    ACT_POP_FREE  = 3'd0,
    ACT_PUSH_FREE = 3'd1,
    ACT_ENQ_USED  = 3'd2,
    ACT_DEQ_USED  = 3'd3,
    ACT_ADDRESS   = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef enum logic {
    REG_FRAG_COUNT = 1'b0,
    REG_FRAG_BYTES = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] index;
  } free_req_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [IDX_W-1:0] top;
  } free_stat_t;

  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [IDX_W-1:0] index;
  } fifo_req_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [IDX_W-1:0] head;
  } fifo_stat_t;

endpackage

>>> src/fpm_free_stack.sv
// Free fragment stack: index memory, stack pointer and registered top-of-stack read.
module fpm_free_stack #(
  parameter int SD = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [$clog2(SD+1)-1:0]  n,
  input  fpm_pkg::free_req_t       req,
  output fpm_pkg::free_stat_t      stat
);
  import fpm_pkg::*;

  localparam int AW = $clog2(SD);
  localparam int CW = $clog2(SD + 1);

  logic [CW-1:0]    fp;
  logic [CW-1:0]    fp_next;
  logic [AW-1:0]    raddr;
  logic [IDX_W-1:0] mem [2**AW];
  logic [2**AW-1:0] valid;
  logic [IDX_W-1:0] rd_data;
  logic             rd_valid;
  logic [AW-1:0]    rd_addr;

  always_comb begin
    fp_next = fp;
    if (req.pop) begin
      fp_next = fp + CW'(1);
    end else if (req.push) begin
      fp_next = fp - CW'(1);
    end
    raddr = fp_next[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[raddr] <= req.index;
    end
    rd_data <= req.push ? req.index : mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp       <= '0;
      valid    <= '0;
      rd_valid <= 1'b0;
      rd_addr  <= '0;
    end else begin
      fp <= fp_next;
      if (req.push) begin
        valid[raddr] <= 1'b1;
      end
      rd_valid <= req.push | valid[raddr];
      rd_addr  <= raddr;
    end
  end

  always_comb begin
    stat.empty = (fp >= n);
    stat.full  = (fp == '0);
    stat.top   = rd_valid ? rd_data : IDX_W'(rd_addr);
  end

endmodule

>>> src/fpm_used_fifo.sv
// Used fragment queue: circular index memory with head, tail and count.
module fpm_used_fifo #(
  parameter int SD = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [$clog2(SD+1)-1:0]  n,
  input  fpm_pkg::fifo_req_t       req,
  output fpm_pkg::fifo_stat_t      stat
);
  import fpm_pkg::*;

  localparam int AW = $clog2(SD);
  localparam int CW = $clog2(SD + 1);

  logic [AW-1:0]    head;
  logic [AW-1:0]    head_next;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    tail_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [IDX_W-1:0] mem [2**AW];
  logic [IDX_W-1:0] rd_data;

  function automatic logic [AW-1:0] succ(input logic [AW-1:0] p, input logic [CW-1:0] lim);
    logic [AW:0] q;
    q = (AW+1)'(p) + (AW+1)'(1);
    return (q >= (AW+1)'(lim)) ? '0 : q[AW-1:0];
  endfunction

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    we         = 1'b0;
    waddr      = '0;
    if (req.enq) begin
      we         = 1'b1;
      count_next = count + CW'(1);
      if (count == '0) begin
        head_next = '0;
        tail_next = '0;
        waddr     = '0;
      end else begin
        tail_next = succ(tail, n);
        waddr     = succ(tail, n);
      end
    end else if (req.deq) begin
      count_next = count - CW'(1);
      if (count == CW'(1)) begin
        head_next = '0;
        tail_next = '0;
      end else begin
        head_next = succ(head, n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= req.index;
    end
    rd_data <= (we && (waddr == head_next)) ? req.index : mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_comb begin
    stat.empty = (count == '0);
    stat.full  = (count >= n);
    stat.head  = rd_data;
  end

endmodule

>>> src/fpm_addr_gen.sv
// Fragment address generator: page count register and index-times-span product.
module fpm_addr_gen #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          bytes_we,
  input  logic [fpm_pkg::BYTES_W-1:0]   bytes_data,
  input  logic [fpm_pkg::IDX_W-1:0]     index,
  output logic [fpm_pkg::ADDR_W-1:0]    byte_address
);
  import fpm_pkg::*;

  localparam int LG    = $clog2(PAGE_BYTES);
  localparam int XW    = BYTES_W + 1;
  localparam int SH    = XW + LG;
  localparam int MW    = XW + 2;
  localparam longint unsigned MAGIC =
    ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam int PGW   = XW + 1 - LG;
  localparam int IPW   = IDX_W + $clog2(PAGE_BYTES + 1);
  localparam int PW    = IPW + PGW;
  localparam int RESET_PAGES = (FRAG_BYTES_RESET + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int ENTRIES = 2**IDX_W;

  logic [XW-1:0]    x;
  logic [XW+MW-1:0] quot_prod;
  logic [PGW-1:0]   pages_calc;
  logic [PGW-1:0]   pages;
  logic [IPW-1:0]   span_rom [ENTRIES];
  logic [PW-1:0]    addr_prod;

  assign x          = XW'(bytes_data) + XW'(PAGE_BYTES - 1);
  assign quot_prod  = (XW+MW)'(x) * (XW+MW)'(MAGIC);
  assign pages_calc = PGW'(quot_prod >> SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      pages <= PGW'(RESET_PAGES);
    end else if (bytes_we) begin
      pages <= pages_calc;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      span_rom[i] = IPW'(i * PAGE_BYTES);
    end
  end

  assign addr_prod    = PW'(span_rom[index]) * PW'(pages);
  assign byte_address = addr_prod[ADDR_W-1:0];

endmodule

>>> src/fragment_pool_manager_top.sv
// Fragment pool manager top level: request register, decode and result register.
// A request waits in the request register until the result register is free.
// Throughput: one request per cycle unless a stalled result holds it; stack and
// queue read ports are pre-read into registers, one read-modify-write pass each.
// Reset: synchronous; stack returns to identity order, queue empties, fragment
// count 64 and fragment size 4096 bytes, ready for a request on the next cycle.
module fragment_pool_manager_top #(
  parameter int DEPTH      = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [fpm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fpm_pkg::ACT_W-1:0]     action,
  input  logic [fpm_pkg::IDX_W-1:0]     index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fpm_pkg::STAT_W-1:0]    status,
  output logic [fpm_pkg::IDX_W-1:0]     index_out,
  output logic [fpm_pkg::ADDR_W-1:0]    byte_address
);
  import fpm_pkg::*;

  localparam int SD   = (DEPTH < 128) ? DEPTH : 128;
  localparam int CW   = $clog2(SD + 1);
  localparam int CMPW = CW + IDX_W;

  logic [COUNT_W-1:0] frag_count;
  logic [CW-1:0]      n;
  logic               in_full;
  logic [ACT_W-1:0]   action_q;
  logic [IDX_W-1:0]   index_q;
  logic               proc;
  logic               idx_ok;
  free_req_t          free_req;
  free_stat_t         free_stat;
  fifo_req_t          fifo_req;
  fifo_stat_t         fifo_stat;
  logic [ADDR_W-1:0]  addr_value;
  status_t            st_next;
  logic [IDX_W-1:0]   iout_next;
  logic [ADDR_W-1:0]  addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_count <= FRAG_COUNT_RESET;
    end else if (cfg_we && (cfg_reg_t'(cfg_index) == REG_FRAG_COUNT)) begin
      frag_count <= cfg_data[COUNT_W-1:0];
    end
  end

  always_comb begin
    if (frag_count == '0) begin
      n = CW'(1);
    end else if (32'(frag_count) > SD) begin
      n = CW'(SD);
    end else begin
      n = CW'(frag_count);
    end
  end

  assign proc     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !proc;
  assign idx_ok   = CMPW'(index_q) < CMPW'(n);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      action_q <= action;
      index_q  <= index;
    end
  end

  fpm_free_stack #(.SD(SD)) u_free_stack (
    .clk  (clk),
    .rst  (rst),
    .n    (n),
    .req  (free_req),
    .stat (free_stat)
  );

  fpm_used_fifo #(.SD(SD)) u_used_fifo (
    .clk  (clk),
    .rst  (rst),
    .n    (n),
    .req  (fifo_req),
    .stat (fifo_stat)
  );

  fpm_addr_gen #(.PAGE_BYTES(PAGE_BYTES)) u_addr_gen (
    .clk          (clk),
    .rst          (rst),
    .bytes_we     (cfg_we && (cfg_reg_t'(cfg_index) == REG_FRAG_BYTES)),
    .bytes_data   (cfg_data[BYTES_W-1:0]),
    .index        (index_q),
    .byte_address (addr_value)
  );

  always_comb begin
    st_next        = ST_OK;
    iout_next      = '0;
    addr_next      = '0;
    free_req       = '0;
    fifo_req       = '0;
    free_req.index = index_q;
    fifo_req.index = index_q;
    case (action_t'(action_q))
      ACT_POP_FREE: begin
        if (free_stat.empty) begin
          st_next = ST_EMPTY;
        end else begin
          iout_next    = free_stat.top;
          free_req.pop = proc;
        end
      end
      ACT_PUSH_FREE: begin
        if (!idx_ok || free_stat.full) begin
          st_next = ST_BAD;
        end else begin
          free_req.push = proc;
        end
      end
      ACT_ENQ_USED: begin
        if (!idx_ok || fifo_stat.full) begin
          st_next = ST_BAD;
        end else begin
          fifo_req.enq = proc;
        end
      end
      ACT_DEQ_USED: begin
        if (fifo_stat.empty) begin
          st_next = ST_EMPTY;
        end else begin
          iout_next    = fifo_stat.head;
          fifo_req.deq = proc;
        end
      end
      ACT_ADDRESS: begin
        if (!idx_ok) begin
          st_next = ST_BAD;
        end else begin
          addr_next = addr_value;
        end
      end
      default: begin
        st_next = ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      status       <= st_next;
      index_out    <= iout_next;
      byte_address <= addr_next;
    end
  end

endmodule

>>> src/fpm_checker.sv
// Port-level checks for the fragment pool manager and their bind to the top level.
module fpm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [fpm_pkg::STAT_W-1:0]    status,
  input logic [fpm_pkg::IDX_W-1:0]     index_out,
  input logic [fpm_pkg::ADDR_W-1:0]    byte_address
);
  import fpm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(index_out)
      && $stable(byte_address))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (index_out == '0) && (byte_address == '0))
    else $error("failed request returned data");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled while result side is free");

  a_stall_clear: assert property (@(posedge clk) disable iff (rst)
    in_stall ##1 !out_stall |-> !in_stall)
    else $error("request side stayed stalled after result transfer");

endmodule

bind fragment_pool_manager_top fpm_checker u_fpm_checker (.*);

>>> tb/testbench.sv
// Testbench for the fragment pool manager: directed and random requests against a pool model.
`timescale 1ns / 1ps

module testbench;
  import fpm_pkg::*;

  localparam int DEPTH      = 64;
  localparam int PAGE_BYTES = 4096;

  localparam logic [ACT_W-1:0] ACT_RSVD_5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
  } outcome_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = REG_FRAG_COUNT;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic [ACT_W-1:0]  action    = '0;
  logic [IDX_W-1:0]  index     = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  index_out;
  logic [ADDR_W-1:0] byte_address;

  fragment_pool_manager_top #(
    .DEPTH(DEPTH),
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .index(index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .index_out(index_out),
    .byte_address(byte_address)
  );

  // pool model
  logic [COUNT_W-1:0] count_reg = FRAG_COUNT_RESET;
  logic [BYTES_W-1:0] bytes_reg = BYTES_W'(FRAG_BYTES_RESET);
  logic [IDX_W-1:0]   pool_stack [DEPTH];
  logic [COUNT_W-1:0] pool_sp;
  logic [IDX_W-1:0]   used_ring [DEPTH];
  logic [IDX_W-1:0]   ring_head;
  logic [IDX_W-1:0]   ring_tail;
  logic [COUNT_W-1:0] ring_fill;

  request_t req_queue [$];
  outcome_t due_results [$];
  request_t next_req;
  outcome_t want;

  int errors       = 0;
  int results_seen = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  bit held         = 1'b0;
  bit quiet        = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int live_count();
    if (count_reg == 0) return 1;
    if (count_reg > DEPTH) return DEPTH;
    return int'(count_reg);
  endfunction

  function automatic logic [IDX_W-1:0] next_slot(int p, int n);
    return (p + 1 >= n) ? '0 : IDX_W'(p + 1);
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int n;
    longint pages;
    n = live_count();
    o = '0;
    o.status = ST_OK;
    case (r.act)
      ACT_POP_FREE: begin
        if (pool_sp >= n) begin
          o.status = ST_EMPTY;
        end else begin
          o.idx = pool_stack[pool_sp];
          pool_sp++;
        end
      end
      ACT_PUSH_FREE: begin
        if (r.idx >= n || pool_sp == 0) begin
          o.status = ST_BAD;
        end else begin
          pool_sp--;
          pool_stack[pool_sp] = r.idx;
        end
      end
      ACT_ENQ_USED: begin
        if (r.idx >= n || ring_fill >= n) begin
          o.status = ST_BAD;
        end else if (ring_fill == 0) begin
          ring_head = '0;
          ring_tail = '0;
          used_ring[0] = r.idx;
          ring_fill = 1;
        end else begin
          ring_tail = next_slot(ring_tail, n);
          used_ring[ring_tail] = r.idx;
          ring_fill++;
        end
      end
      ACT_DEQ_USED: begin
        if (ring_fill == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.idx = used_ring[ring_head];
          ring_fill--;
          if (ring_fill == 0) begin
            ring_head = '0;
            ring_tail = '0;
          end else begin
            ring_head = next_slot(ring_head, n);
          end
        end
      end
      ACT_ADDRESS: begin
        if (r.idx >= n) begin
          o.status = ST_BAD;
        end else begin
          pages = (longint'(bytes_reg) + PAGE_BYTES - 1) / PAGE_BYTES;
          o.addr = ADDR_W'(longint'(r.idx) * pages * PAGE_BYTES);
        end
      end
      default: o.status = ST_BAD;
    endcase
    return o;
  endfunction

  task automatic add_req(logic [ACT_W-1:0] a, logic [IDX_W-1:0] i);
    req_queue.push_back(request_t'{act: a, idx: i});
  endtask

  task automatic write_reg(cfg_reg_t r, int unsigned v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == REG_FRAG_COUNT) count_reg = COUNT_W'(v);
    else bytes_reg = BYTES_W'(v);
    @(negedge clk);
  endtask

  task automatic settle();
    while (req_queue.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // lean selects whether a block of requests starts allocation-heavy or release-heavy
  task automatic run_mix(int items, int lean);
    int n;
    int pick;
    logic [ACT_W-1:0] a;
    for (int k = 0; k < items; k++) begin
      n = live_count();
      if ($urandom_range(0, 9) == 0) begin
        add_req(ACT_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 63)));
      end else begin
        pick = $urandom_range(0, 99);
        if (((k / 64) + lean) % 2 == 0) begin
          if (pick < 35) a = ACT_POP_FREE;
          else if (pick < 65) a = ACT_ENQ_USED;
          else if (pick < 80) a = ACT_ADDRESS;
          else if (pick < 90) a = ACT_PUSH_FREE;
          else a = ACT_DEQ_USED;
        end else begin
          if (pick < 35) a = ACT_PUSH_FREE;
          else if (pick < 70) a = ACT_DEQ_USED;
          else if (pick < 80) a = ACT_ADDRESS;
          else if (pick < 90) a = ACT_POP_FREE;
          else a = ACT_ENQ_USED;
        end
        add_req(a, IDX_W'($urandom_range(0, n - 1)));
      end
    end
  endtask

  task automatic run_phase(int unsigned cnt, int unsigned bytes, int lean, int items);
    write_reg(REG_FRAG_COUNT, cnt);
    write_reg(REG_FRAG_BYTES, bytes);
    run_mix(items, lean);
    settle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        due_results.push_back(apply_request(request_t'{act: action, idx: index}));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          next_req = req_queue.pop_front();
          in_valid <= 1'b1;
          action   <= next_req.act;
          index    <= next_req.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: status %0d index %0d address %0d",
                   $time, status, index_out, byte_address);
        end else begin
          want = due_results.pop_front();
          if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
          if (index_out !== want.idx) begin
            errors++;
            $display("%0t: index_out expected %0d actual %0d", $time, want.idx, index_out);
          end
          if (byte_address !== want.addr) begin
            errors++;
            $display("%0t: byte_address expected %0d actual %0d",
                     $time, want.addr, byte_address);
          end
        end
      end
      // hold off once for a long stretch so the request side backs up
      if (!held && results_seen > 100 && req_queue.size() > 20) begin
        held = 1'b1;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) pool_stack[i] = IDX_W'(i);
    for (int i = 0; i < DEPTH; i++) used_ring[i] = '0;
    pool_sp   = '0;
    ring_head = '0;
    ring_tail = '0;
    ring_fill = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the used queue once so every slot holds a written index, then drain it
    for (int k = 0; k < DEPTH; k++) add_req(ACT_ENQ_USED, IDX_W'($urandom_range(0, 63)));
    add_req(ACT_ENQ_USED, 6'd7);
    for (int k = 0; k <= DEPTH; k++) add_req(ACT_DEQ_USED, '0);
    settle();

    // push onto full stack, pops, address extremes, unknown actions
    add_req(ACT_PUSH_FREE, 6'd5);
    add_req(ACT_POP_FREE, '0);
    add_req(ACT_POP_FREE, '0);
    add_req(ACT_PUSH_FREE, 6'd63);
    add_req(ACT_POP_FREE, '0);
    add_req(ACT_ADDRESS, 6'd0);
    add_req(ACT_ADDRESS, 6'd63);
    add_req(ACT_RSVD_5, 6'd63);
    add_req(ACT_RSVD_6, 6'd0);
    add_req(ACT_RSVD_7, 6'd42);
    settle();

    // small pool: bad indices, full queue, tail wrap, empty stack and queue
    write_reg(REG_FRAG_COUNT, 3);
    add_req(ACT_PUSH_FREE, 6'd3);
    add_req(ACT_ADDRESS, 6'd3);
    add_req(ACT_ENQ_USED, 6'd5);
    add_req(ACT_ENQ_USED, 6'd0);
    add_req(ACT_ENQ_USED, 6'd1);
    add_req(ACT_ENQ_USED, 6'd2);
    add_req(ACT_ENQ_USED, 6'd1);
    add_req(ACT_DEQ_USED, '0);
    add_req(ACT_ENQ_USED, 6'd2);
    repeat (4) add_req(ACT_DEQ_USED, '0);
    add_req(ACT_POP_FREE, '0);
    add_req(ACT_POP_FREE, '0);
    settle();

    // zero count acts as one, zero size gives address zero
    write_reg(REG_FRAG_COUNT, 0);
    write_reg(REG_FRAG_BYTES, 0);
    add_req(ACT_ADDRESS, 6'd0);
    add_req(ACT_ADDRESS, 6'd1);
    settle();

    // count above depth, widest size: address truncates
    write_reg(REG_FRAG_COUNT, 127);
    write_reg(REG_FRAG_BYTES, 2097151);
    add_req(ACT_ADDRESS, 6'd63);
    add_req(ACT_ADDRESS, 6'd1);
    settle();

    run_phase(64, 4096, 0, 100);
    run_phase(64, $urandom_range(1, 1048576), 1, 100);
    run_phase(8, 1, 0, 100);
    run_phase(0, 0, 1, 60);
    run_phase(127, 2097151, 0, 100);
    run_phase(100, 1048576, 1, 100);
    run_phase($urandom_range(2, 63), $urandom_range(0, 2097151), 0, 100);
    quiet = 1'b1;
    run_phase(16, 4097, 1, 100);

    repeat (10) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
src/fpm_pkg.sv
src/fpm_free_stack.sv
src/fpm_used_fifo.sv
src/fpm_addr_gen.sv
src/fragment_pool_manager_top.sv
src/fpm_checker.sv
tb/testbench.sv
